>>> rtl/core/flog_pkg.sv
// ----------------------------------------------------------------------------
// flog_pkg
// Shared types, constants and exact rounding arithmetic for the float32
// natural log pipeline.
// ----------------------------------------------------------------------------
package flog_pkg;

  localparam int SIG_W   = 64;
  localparam int EXP_W   = 12;
  localparam int FLT_P   = 24;
  localparam int DBL_P   = 53;
  localparam int PROD_W  = 61;
  localparam int DIV1_DW = 25;
  localparam int DIV1_QW = 57;
  localparam int DIV2_DW = 24;
  localparam int DIV2_QW = 26;

  localparam logic [31:0] LOG_MOST_NEG = 32'hFF7F_FFFF;
  localparam logic [31:0] LOG_QNAN     = 32'h7FC0_0000;
  localparam logic [31:0] LOG_ONE      = 32'h3F80_0000;
  localparam logic [31:0] COEF_P0      = 32'hBF8A_4799;
  localparam logic [31:0] COEF_P1      = 32'h4000_0000;
  localparam logic [31:0] COEF_Q0      = 32'h3DBA_F34C;
  localparam logic [31:0] COEF_Q1      = 32'hBF5F_9D2B;
  localparam logic [52:0] LN2_SIG      = 53'h16_2E42_FEFA_39EF;

  localparam logic signed [EXP_W-1:0] EXP_ZERO = 12'sh800;

  // value = (-1)^sgn * sig * 2^(ex - 63), sig normalized with bit 63 set
  typedef struct packed {
    logic                    sgn;
    logic signed [EXP_W-1:0] ex;
    logic [SIG_W-1:0]        sig;
  } fnum_t;

  // unnormalized exact sum: value = mag * 2^(ex - 127), st = nonzero tail
  typedef struct packed {
    logic                    sgn;
    logic signed [EXP_W-1:0] ex;
    logic [128:0]            mag;
    logic                    st;
  } fsum_t;

  typedef struct packed {
    logic        special;
    logic [31:0] spec_bits;
    logic        bad;
  } tag_t;

  typedef struct packed {
    tag_t              tag;
    logic              nneg;
    logic [PROD_W-1:0] prod;
    logic [4:0]        sh;
  } div1_ctx_t;

  typedef struct packed {
    tag_t                    tag;
    fnum_t                   lnk;
    logic                    sgn;
    logic signed [EXP_W-1:0] ex;
  } div2_ctx_t;

  function automatic fnum_t unpack32(input logic [31:0] b);
    fnum_t r;
    r.sgn = b[31];
    r.ex  = $signed({4'b0, b[30:23]}) - 12'sd127;
    r.sig = {1'b1, b[22:0], 40'b0};
    return r;
  endfunction

  function automatic logic [31:0] pack32(input fnum_t a);
    logic [EXP_W-1:0] eb;
    eb = a.ex + 12'sd127;
    return {a.sgn, eb[7:0], a.sig[62:40]};
  endfunction

  // round to nearest even at p significant bits
  function automatic fnum_t round_p(input fnum_t a, input logic st, input int p);
    logic [SIG_W-1:0] unit;
    logic [SIG_W-1:0] low_mask;
    logic [SIG_W-1:0] trunc;
    logic             lsb;
    logic             guard;
    logic             rest;
    logic [SIG_W:0]   sum;
    fnum_t            r;
    unit     = 64'd1 << (SIG_W - p);
    low_mask = unit - 64'd1;
    trunc    = a.sig & ~low_mask;
    lsb      = |(a.sig & unit);
    guard    = |(a.sig & (unit >> 1));
    rest     = (|(a.sig & (low_mask >> 1))) | st;
    sum      = {1'b0, trunc} + ((guard & (rest | lsb)) ? {1'b0, unit} : 65'd0);
    r = a;
    if (sum[SIG_W]) begin
      r.sig = sum[SIG_W:1];
      r.ex  = a.ex + 12'sd1;
    end else begin
      r.sig = sum[SIG_W-1:0];
    end
    return r;
  endfunction

  function automatic fnum_t fmul(input fnum_t a, input fnum_t b);
    logic [47:0] pr;
    fnum_t       r;
    pr    = a.sig[63:40] * b.sig[63:40];
    r.sgn = a.sgn ^ b.sgn;
    if (pr[47]) begin
      r.sig = {pr, 16'b0};
      r.ex  = a.ex + b.ex + 12'sd1;
    end else begin
      r.sig = {pr[46:0], 17'b0};
      r.ex  = a.ex + b.ex;
    end
    return round_p(r, 1'b0, FLT_P);
  endfunction

  function automatic fsum_t fadd_raw(input fnum_t a, input fnum_t b);
    fnum_t        big;
    fnum_t        sml;
    logic [12:0]  d;
    logic [7:0]   dd;
    logic [255:0] t;
    logic [128:0] bw;
    logic [128:0] sw;
    fsum_t        r;
    if (($signed(b.ex) > $signed(a.ex)) || ((b.ex == a.ex) && (b.sig > a.sig))) begin
      big = b;
      sml = a;
    end else begin
      big = a;
      sml = b;
    end
    d    = {big.ex[EXP_W-1], big.ex} - {sml.ex[EXP_W-1], sml.ex};
    dd   = (d > 13'd191) ? 8'd191 : d[7:0];
    bw   = {1'b0, big.sig, 64'b0};
    t    = {1'b0, sml.sig, 191'b0} >> dd;
    sw   = t[255:127];
    r.st = |t[126:0];
    if (a.sgn ^ b.sgn) begin
      r.mag = bw - sw - {128'b0, r.st};
    end else begin
      r.mag = bw + sw;
    end
    r.sgn = big.sgn;
    r.ex  = big.ex;
    return r;
  endfunction

  // normalize, then round to float, optionally through double first
  function automatic fnum_t fnorm(input fsum_t s, input logic dbl);
    logic [7:0]   lz;
    logic [128:0] nm;
    logic         st;
    fnum_t        r;
    lz = 8'd0;
    for (int i = 0; i <= 128; i++) begin
      if (s.mag[i]) lz = 8'(128 - i);
    end
    nm    = s.mag << lz;
    st    = (|nm[64:0]) | s.st;
    r.sgn = s.sgn;
    r.sig = nm[128:65];
    r.ex  = s.ex + 12'sd1 - $signed({4'b0, lz});
    if (dbl) begin
      r = round_p(round_p(r, st, DBL_P), 1'b0, FLT_P);
    end else begin
      r = round_p(r, st, FLT_P);
    end
    return r;
  endfunction

endpackage

>>> rtl/core/float32_natural_log_top.sv
// ----------------------------------------------------------------------------
// float32_natural_log_top
// Single-precision natural logarithm, fully pipelined. One operand is
// accepted every cycle while the output is not stalled. The pipeline is
// made of the two restoring dividers, one quotient bit per stage (57 stages
// for s = (m-1)/(m+1) at double precision, 26 for the final float
// quotient), plus 13 stages of classification, multiply, add and rounding.
// A stall at the output holds every stage in place. Zero returns the most
// negative finite float, negative, infinite and NaN operands return a quiet
// NaN with invalid_input set.
// ----------------------------------------------------------------------------
module float32_natural_log_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        operand_valid,
  output logic        operand_ready,
  input  logic [31:0] operand_bits,
  output logic        log_valid,
  input  logic        log_ready,
  output logic [31:0] log_bits,
  output logic        invalid_input
);
  import flog_pkg::*;

  logic ce;

  logic               fr_valid;
  logic [DIV1_DW-1:0] fr_num;
  logic [DIV1_DW-1:0] fr_dvs;
  div1_ctx_t          fr_ctx;

  logic                      d1_valid;
  logic [DIV1_QW-1:0]        d1_quo;
  logic                      d1_rem_nz;
  logic [$bits(div1_ctx_t)-1:0] d1_side;

  logic               md_valid;
  logic [DIV2_DW-1:0] md_num;
  logic [DIV2_DW-1:0] md_den;
  div2_ctx_t          md_ctx;

  logic                      d2_valid;
  logic [DIV2_QW-1:0]        d2_quo;
  logic                      d2_rem_nz;
  logic [$bits(div2_ctx_t)-1:0] d2_side;

  assign ce            = ~log_valid | log_ready;
  assign operand_ready = ce;

  flog_front u_front (
    .clk          (clk),
    .rst          (rst),
    .ce           (ce),
    .in_valid     (operand_valid),
    .operand_bits (operand_bits),
    .out_valid    (fr_valid),
    .num          (fr_num),
    .dvs          (fr_dvs),
    .ctx          (fr_ctx)
  );

  flog_div #(
    .DW  (DIV1_DW),
    .QW  (DIV1_QW),
    .SBW ($bits(div1_ctx_t))
  ) u_div_ratio (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (fr_valid),
    .num       (fr_num),
    .dvs       (fr_dvs),
    .side      (fr_ctx),
    .out_valid (d1_valid),
    .quo       (d1_quo),
    .rem_nz    (d1_rem_nz),
    .side_out  (d1_side)
  );

  flog_mid u_mid (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (d1_valid),
    .quo       (d1_quo),
    .rem_nz    (d1_rem_nz),
    .ctx_in    (div1_ctx_t'(d1_side)),
    .out_valid (md_valid),
    .num_sig   (md_num),
    .den_sig   (md_den),
    .ctx_out   (md_ctx)
  );

  flog_div #(
    .DW  (DIV2_DW),
    .QW  (DIV2_QW),
    .SBW ($bits(div2_ctx_t))
  ) u_div_poly (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (md_valid),
    .num       (md_num),
    .dvs       (md_den),
    .side      (md_ctx),
    .out_valid (d2_valid),
    .quo       (d2_quo),
    .rem_nz    (d2_rem_nz),
    .side_out  (d2_side)
  );

  flog_back u_back (
    .clk           (clk),
    .rst           (rst),
    .ce            (ce),
    .in_valid      (d2_valid),
    .quo           (d2_quo),
    .rem_nz        (d2_rem_nz),
    .ctx_in        (div2_ctx_t'(d2_side)),
    .out_valid     (log_valid),
    .log_bits      (log_bits),
    .invalid_input (invalid_input)
  );

endmodule

>>> rtl/core/flog_div.sv
// ----------------------------------------------------------------------------
// flog_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module flog_div #(
  parameter int DW  = 25,
  parameter int QW  = 57,
  parameter int SBW = 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           ce,
  input  logic           in_valid,
  input  logic [DW-1:0]  num,
  input  logic [DW-1:0]  dvs,
  input  logic [SBW-1:0] side,
  output logic           out_valid,
  output logic [QW-1:0]  quo,
  output logic           rem_nz,
  output logic [SBW-1:0] side_out
);

  logic           vld [QW];
  logic [DW:0]    rem [QW];
  logic [DW-1:0]  dv  [QW];
  logic [QW-1:0]  qt  [QW];
  logic [SBW-1:0] sb  [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic           v_in;
    logic [DW:0]    r_in;
    logic [DW-1:0]  d_in;
    logic [QW-1:0]  q_in;
    logic [SBW-1:0] s_in;
    logic           ge;
    logic [DW:0]    r_sub;

    if (i == 0) begin : g_first
      assign v_in = in_valid;
      assign r_in = {1'b0, num};
      assign d_in = dvs;
      assign q_in = '0;
      assign s_in = side;
    end else begin : g_next
      assign v_in = vld[i-1];
      assign r_in = rem[i-1];
      assign d_in = dv[i-1];
      assign q_in = qt[i-1];
      assign s_in = sb[i-1];
    end

    assign ge    = r_in >= {1'b0, d_in};
    assign r_sub = ge ? (r_in - {1'b0, d_in}) : r_in;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (ce) begin
        vld[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        rem[i] <= {r_sub[DW-1:0], 1'b0};
        dv[i]  <= d_in;
        qt[i]  <= {q_in[QW-2:0], ge};
        sb[i]  <= s_in;
      end
    end
  end

  assign out_valid = vld[QW-1];
  assign quo       = qt[QW-1];
  assign rem_nz    = |rem[QW-1];
  assign side_out  = sb[QW-1];

endmodule

>>> rtl/core/flog_front.sv
// ----------------------------------------------------------------------------
// flog_front
// Operand classification, subnormal normalization, quotient operand setup
// and the exponent times ln2 product.
// ----------------------------------------------------------------------------
module flog_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           ce,
  input  logic                           in_valid,
  input  logic [31:0]                    operand_bits,
  output logic                           out_valid,
  output logic [flog_pkg::DIV1_DW-1:0]   num,
  output logic [flog_pkg::DIV1_DW-1:0]   dvs,
  output flog_pkg::div1_ctx_t            ctx
);
  import flog_pkg::*;

  // stage 1
  tag_t              tag_c;
  logic [4:0]        k_c;
  logic [23:0]       m_c;
  logic signed [8:0] n_c;
  logic              v1;
  tag_t              tag1;
  logic [23:0]       m1;
  logic signed [8:0] n1;

  always_comb begin
    tag_c.special   = 1'b1;
    tag_c.bad       = 1'b0;
    tag_c.spec_bits = 32'h0;
    if (operand_bits[30:0] == 31'h0) begin
      tag_c.spec_bits = LOG_MOST_NEG;
    end else if (operand_bits[31] || (operand_bits[30:23] == 8'hFF)) begin
      tag_c.spec_bits = LOG_QNAN;
      tag_c.bad       = 1'b1;
    end else if (operand_bits != LOG_ONE) begin
      tag_c.special = 1'b0;
    end
    k_c = 5'd0;
    for (int i = 0; i < 23; i++) begin
      if (operand_bits[i]) k_c = 5'(23 - i);
    end
    if (operand_bits[30:23] == 8'h00) begin
      m_c = {1'b0, operand_bits[22:0]} << k_c;
      n_c = -9'sd125 - $signed({4'b0, k_c});
    end else begin
      m_c = {1'b1, operand_bits[22:0]};
      n_c = $signed({1'b0, operand_bits[30:23]}) - 9'sd126;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ce) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      tag1 <= tag_c;
      m1   <= m_c;
      n1   <= n_c;
    end
  end

  // stage 2
  logic [DIV1_DW-1:0] nv;
  logic [4:0]         lz;
  logic [8:0]         an;
  div1_ctx_t          ctx_c;

  always_comb begin
    nv = 25'h100_0000 - {1'b0, m1};
    lz = 5'd0;
    for (int i = 0; i < DIV1_DW; i++) begin
      if (nv[i]) lz = 5'(24 - i);
    end
    an            = n1[8] ? 9'(-n1) : 9'(n1);
    ctx_c.tag     = tag1;
    ctx_c.nneg    = n1[8];
    ctx_c.prod    = PROD_W'(an[7:0]) * PROD_W'(LN2_SIG);
    ctx_c.sh      = lz;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ce) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      num <= nv << lz;
      dvs <= 25'h100_0000 + {1'b0, m1};
      ctx <= ctx_c;
    end
  end

endmodule

>>> rtl/core/flog_mid.sv
// ----------------------------------------------------------------------------
// flog_mid
// Rounds the ratio s, evaluates numerator and denominator polynomials and
// forms the operands of the final float division.
// ----------------------------------------------------------------------------
module flog_mid (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         ce,
  input  logic                         in_valid,
  input  logic [flog_pkg::DIV1_QW-1:0] quo,
  input  logic                         rem_nz,
  input  flog_pkg::div1_ctx_t          ctx_in,
  output logic                         out_valid,
  output logic [flog_pkg::DIV2_DW-1:0] num_sig,
  output logic [flog_pkg::DIV2_DW-1:0] den_sig,
  output flog_pkg::div2_ctx_t          ctx_out
);
  import flog_pkg::*;

  localparam fnum_t CP0  = unpack32(COEF_P0);
  localparam fnum_t CP1  = unpack32(COEF_P1);
  localparam fnum_t CQ0  = unpack32(COEF_Q0);
  localparam fnum_t CQ1  = unpack32(COEF_Q1);
  localparam fnum_t CONE = unpack32(LOG_ONE);

  // stage A: s and n*ln2
  fnum_t       s_raw;
  fnum_t       lnk_raw;
  logic [63:0] pw;
  logic [5:0]  pk;

  always_comb begin
    s_raw.sgn = 1'b1;
    if (quo[DIV1_QW-1]) begin
      s_raw.sig = {quo, {(SIG_W - DIV1_QW){1'b0}}};
      s_raw.ex  = 12'sd0 - $signed({7'b0, ctx_in.sh});
    end else begin
      s_raw.sig = {quo[DIV1_QW-2:0], {(SIG_W - DIV1_QW + 1){1'b0}}};
      s_raw.ex  = -12'sd1 - $signed({7'b0, ctx_in.sh});
    end
    pw = {{(SIG_W - PROD_W){1'b0}}, ctx_in.prod};
    pk = 6'd0;
    for (int i = 0; i < SIG_W; i++) begin
      if (pw[i]) pk = 6'(63 - i);
    end
    lnk_raw.sgn = ctx_in.nneg;
    lnk_raw.sig = pw << pk;
    lnk_raw.ex  = (pw == 64'h0) ? EXP_ZERO : (12'sd10 - $signed({6'b0, pk}));
  end

  logic  va, vb, vc, vd, ve, vf, vg, vh;
  tag_t  tga, tgb, tgc, tgd, tge, tgf, tgg, tgh;
  fnum_t lka, lkb, lkc, lkd, lke, lkf, lkg, lkh;
  fnum_t sa, sb, sc, sd, se;
  fnum_t yb, yc, yd, ye;
  fnum_t t1c, t3c;
  fsum_t a1d, a3d;
  fnum_t nume, d1e;
  fnum_t r1f, r1g, r1h;
  fnum_t d2f;
  fsum_t ag;
  fnum_t dnh;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
      ve <= 1'b0;
      vf <= 1'b0;
      vg <= 1'b0;
      vh <= 1'b0;
    end else if (ce) begin
      va <= in_valid;
      vb <= va;
      vc <= vb;
      vd <= vc;
      ve <= vd;
      vf <= ve;
      vg <= vf;
      vh <= vg;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      tga <= ctx_in.tag;
      lka <= round_p(lnk_raw, 1'b0, DBL_P);
      sa  <= round_p(round_p(s_raw, rem_nz, DBL_P), 1'b0, FLT_P);

      tgb <= tga;
      lkb <= lka;
      sb  <= sa;
      yb  <= fmul(sa, sa);

      tgc <= tgb;
      lkc <= lkb;
      sc  <= sb;
      yc  <= yb;
      t1c <= fmul(CP0, yb);
      t3c <= fmul(CQ0, yb);

      tgd <= tgc;
      lkd <= lkc;
      sd  <= sc;
      yd  <= yc;
      a1d <= fadd_raw(t1c, CP1);
      a3d <= fadd_raw(t3c, CQ1);

      tge  <= tgd;
      lke  <= lkd;
      se   <= sd;
      ye   <= yd;
      nume <= fnorm(a1d, 1'b0);
      d1e  <= fnorm(a3d, 1'b0);

      tgf <= tge;
      lkf <= lke;
      r1f <= fmul(se, nume);
      d2f <= fmul(d1e, ye);

      tgg <= tgf;
      lkg <= lkf;
      r1g <= r1f;
      ag  <= fadd_raw(d2f, CONE);

      tgh <= tgg;
      lkh <= lkg;
      r1h <= r1g;
      dnh <= fnorm(ag, 1'b1);
    end
  end

  assign out_valid   = vh;
  assign num_sig     = r1h.sig[SIG_W-1 -: DIV2_DW];
  assign den_sig     = dnh.sig[SIG_W-1 -: DIV2_DW];
  assign ctx_out.tag = tgh;
  assign ctx_out.lnk = lkh;
  assign ctx_out.sgn = r1h.sgn ^ dnh.sgn;
  assign ctx_out.ex  = r1h.ex - dnh.ex;

endmodule

>>> rtl/core/flog_back.sv
// ----------------------------------------------------------------------------
// flog_back
// Rounds the polynomial quotient, adds n*ln2 and drives the output register.
// ----------------------------------------------------------------------------
module flog_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         ce,
  input  logic                         in_valid,
  input  logic [flog_pkg::DIV2_QW-1:0] quo,
  input  logic                         rem_nz,
  input  flog_pkg::div2_ctx_t          ctx_in,
  output logic                         out_valid,
  output logic [31:0]                  log_bits,
  output logic                         invalid_input
);
  import flog_pkg::*;

  fnum_t q_raw;
  fnum_t lnk_res;

  always_comb begin
    q_raw.sgn = ctx_in.sgn;
    if (quo[DIV2_QW-1]) begin
      q_raw.sig = {quo, {(SIG_W - DIV2_QW){1'b0}}};
      q_raw.ex  = ctx_in.ex;
    end else begin
      q_raw.sig = {quo[DIV2_QW-2:0], {(SIG_W - DIV2_QW + 1){1'b0}}};
      q_raw.ex  = ctx_in.ex - 12'sd1;
    end
  end

  logic  vi, vj;
  tag_t  tgi, tgj;
  fnum_t lki;
  fnum_t ri;
  fsum_t aj;

  always_ff @(posedge clk) begin
    if (rst) begin
      vi        <= 1'b0;
      vj        <= 1'b0;
      out_valid <= 1'b0;
    end else if (ce) begin
      vi        <= in_valid;
      vj        <= vi;
      out_valid <= vj;
    end
  end

  assign lnk_res = fnorm(aj, 1'b1);

  always_ff @(posedge clk) begin
    if (ce) begin
      tgi <= ctx_in.tag;
      lki <= ctx_in.lnk;
      ri  <= round_p(q_raw, rem_nz, FLT_P);

      tgj <= tgi;
      aj  <= fadd_raw(ri, lki);

      log_bits      <= tgj.special ? tgj.spec_bits : pack32(lnk_res);
      invalid_input <= tgj.bad;
    end
  end

endmodule
